// ===== rtl/trt_pkg.sv =====
// trt_pkg: shared types and constants for the tagged response table.
// No dependencies; used by trt_cmp and tagged_response_table.
`timescale 1ns / 1ps
`default_nettype none

package trt_pkg;

  localparam int DEF_ENTRIES  = 8;
  localparam int DEF_KEY_BITS = 64;

  localparam int KEY_IN_W = 64;
  localparam int TIME_W   = 32;
  localparam int VER_W    = 32;
  localparam int CODE_W   = 64;
  localparam int SLOT_W   = 3;
  localparam int KIND_W   = 2;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_FIND  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;

  typedef struct packed {
    logic key_eq;
    logic time_lt;
  } trt_cmp_t;

endpackage

`default_nettype wire

// ===== rtl/trt_mem.sv =====
// trt_mem: slot payload storage, one write and one registered read per cycle.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module trt_mem #(
  parameter int ENTRIES = 8,
  parameter int WIDTH   = 193,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/trt_cmp.sv =====
// trt_cmp: shared compare unit, key equality and unsigned timestamp order.
// Depends on trt_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module trt_cmp #(
  parameter int KEY_BITS = 64
) (
  input  wire logic [KEY_BITS-1:0]      key_a_i,
  input  wire logic [KEY_BITS-1:0]      key_b_i,
  input  wire logic [trt_pkg::TIME_W-1:0] time_a_i,
  input  wire logic [trt_pkg::TIME_W-1:0] time_b_i,
  output trt_pkg::trt_cmp_t             cmp_o
);

  import trt_pkg::*;

  always_comb begin
    cmp_o.key_eq  = (key_a_i == key_b_i);
    cmp_o.time_lt = (time_a_i < time_b_i);
  end

endmodule

`default_nettype wire

// ===== rtl/tagged_response_table.sv =====
// Tagged response table: ENTRIES slots keyed by request tag. An item is taken
// when start_i is high and busy_o low; the sequencer then reads one slot per
// cycle from the payload memory and checks it in a single compare unit. A hit
// or, for a store, a free slot ends the scan; otherwise the scan runs to the
// last slot (eviction or find miss). The result appears in the cycle after
// busy_o's last high cycle. The result is shown for one cycle with done_o
// and must be taken then; there is no back-pressure.
// Depends on trt_pkg, trt_mem and trt_cmp.
`timescale 1ns / 1ps
`default_nettype none

module tagged_response_table #(
  parameter int ENTRIES  = trt_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = trt_pkg::DEF_KEY_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           req_type_i,
  input  wire logic [trt_pkg::KEY_IN_W-1:0]   key_i,
  input  wire logic [trt_pkg::TIME_W-1:0]     now_ms_i,
  input  wire logic                           ok_flag_i,
  input  wire logic [trt_pkg::VER_W-1:0]      version_in_i,
  input  wire logic [trt_pkg::CODE_W-1:0]     code_in_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [trt_pkg::KIND_W-1:0]          store_kind_o,
  output logic [trt_pkg::SLOT_W-1:0]          slot_o,
  output logic                                ok_out_o,
  output logic [trt_pkg::VER_W-1:0]           version_out_o,
  output logic [trt_pkg::CODE_W-1:0]          code_out_o
);

  import trt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int DW    = KEY_BITS + TIME_W + 1 + VER_W + CODE_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [0:0] {
    IDLE,
    SCAN
  } state_e;

  state_e               state_q;
  logic                 req_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [TIME_W-1:0]    time_q;
  logic                 ok_q;
  logic [VER_W-1:0]     ver_q;
  logic [CODE_W-1:0]    code_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     eidx_q;
  logic                 evld_q;
  logic [ENTRIES-1:0]   vld_q;
  logic [TIME_W-1:0]    oldest_q;
  logic [IDX_W-1:0]     victim_q;
  logic                 done_q;
  logic                 hit_q;
  logic [KIND_W-1:0]    kind_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 ok_out_q;
  logic [VER_W-1:0]     ver_out_q;
  logic [CODE_W-1:0]    code_out_q;

  logic [DW-1:0]        wdata;
  logic [DW-1:0]        rdata;
  logic [KEY_BITS-1:0]  r_key;
  logic [TIME_W-1:0]    r_time;
  logic                 r_ok;
  logic [VER_W-1:0]     r_ver;
  logic [CODE_W-1:0]    r_code;
  trt_cmp_t             cmp;

  logic                 cur_vld;
  logic                 match;
  logic                 take_old;
  logic [TIME_W-1:0]    oldest_d;
  logic [IDX_W-1:0]     victim_d;
  logic                 fin;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [KIND_W-1:0]    kind;
  logic                 found;

  assign wdata  = {key_q, time_q, ok_q, ver_q, code_q};
  assign r_key  = rdata[DW-1 -: KEY_BITS];
  assign r_time = rdata[CODE_W+VER_W+1 +: TIME_W];
  assign r_ok   = rdata[CODE_W+VER_W];
  assign r_ver  = rdata[CODE_W +: VER_W];
  assign r_code = rdata[CODE_W-1:0];

  trt_mem #(
    .ENTRIES (ENTRIES),
    .WIDTH   (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  trt_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .key_a_i  (key_q),
    .key_b_i  (r_key),
    .time_a_i (r_time),
    .time_b_i (oldest_q),
    .cmp_o    (cmp)
  );

  // evaluation of the slot whose data is on the read port
  always_comb begin
    cur_vld  = vld_q[eidx_q];
    match    = cur_vld && cmp.key_eq;
    take_old = (eidx_q == '0) || cmp.time_lt;
    oldest_d = take_old ? r_time : oldest_q;
    victim_d = take_old ? eidx_q : victim_q;
    fin      = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = eidx_q;
    kind     = KIND_UPDATE;
    found    = 1'b0;
    if (state_q == SCAN && evld_q) begin
      if (req_q == REQ_STORE) begin
        if (match) begin
          fin   = 1'b1;
          wr_en = 1'b1;
          kind  = KIND_UPDATE;
        end else if (!cur_vld) begin
          fin   = 1'b1;
          wr_en = 1'b1;
          kind  = KIND_FREE;
        end else if (eidx_q == LAST) begin
          fin    = 1'b1;
          wr_en  = 1'b1;
          kind   = KIND_EVICT;
          wr_idx = victim_d;
        end
      end else begin
        if (match) begin
          fin   = 1'b1;
          found = 1'b1;
        end else if (eidx_q == LAST) begin
          fin = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      req_q      <= REQ_STORE;
      key_q      <= '0;
      time_q     <= '0;
      ok_q       <= 1'b0;
      ver_q      <= '0;
      code_q     <= '0;
      idx_q      <= '0;
      eidx_q     <= '0;
      evld_q     <= 1'b0;
      vld_q      <= '0;
      oldest_q   <= '0;
      victim_q   <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      kind_q     <= KIND_UPDATE;
      slot_q     <= '0;
      ok_out_q   <= 1'b0;
      ver_out_q  <= '0;
      code_out_q <= '0;
    end else begin
      done_q <= fin;
      case (state_q)
        IDLE: begin
          if (start_i) begin
            req_q   <= req_type_i;
            key_q   <= key_i[KEY_BITS-1:0];
            time_q  <= now_ms_i;
            ok_q    <= ok_flag_i;
            ver_q   <= version_in_i;
            code_q  <= code_in_i;
            idx_q   <= '0;
            evld_q  <= 1'b0;
            state_q <= SCAN;
          end
        end
        SCAN: begin
          evld_q <= !fin;
          eidx_q <= idx_q;
          if (idx_q != LAST) begin
            idx_q <= idx_q + 1'b1;
          end
          if (evld_q) begin
            oldest_q <= oldest_d;
            victim_q <= victim_d;
          end
          if (fin) begin
            state_q <= IDLE;
            if (req_q == REQ_STORE) begin
              hit_q      <= 1'b1;
              kind_q     <= kind;
              slot_q     <= SLOT_W'(wr_idx);
              ok_out_q   <= 1'b0;
              ver_out_q  <= '0;
              code_out_q <= '0;
            end else begin
              hit_q      <= found;
              kind_q     <= KIND_UPDATE;
              slot_q     <= found ? SLOT_W'(eidx_q) : '0;
              ok_out_q   <= found ? r_ok : 1'b0;
              ver_out_q  <= found ? r_ver : '0;
              code_out_q <= found ? r_code : '0;
            end
            if (wr_en) begin
              vld_q[wr_idx] <= 1'b1;
            end
            if (found) begin
              vld_q[eidx_q] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != IDLE);
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign store_kind_o  = kind_q;
  assign slot_o        = slot_q;
  assign ok_out_o      = ok_out_q;
  assign version_out_o = ver_out_q;
  assign code_out_o    = code_out_q;

  a_done_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == SCAN))
    else $error("result without a scan");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not start a scan");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (store_kind_o == KIND_UPDATE && slot_o == '0 &&
                            !ok_out_o && version_out_o == '0 && code_out_o == '0))
    else $error("find miss with nonzero fields");

  a_write_marks_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(wr_idx)])
    else $error("written slot not marked valid");

endmodule

`default_nettype wire
